// ----- src/sdfl_pkg.sv -----
// shared types, constants and codes of the slot directory free list
package sdfl_pkg;

  localparam int SLOTS   = 256;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int PAGE_W  = 31;
  localparam int WORD_W  = 32;
  localparam int REQ_W   = 2;
  localparam int TDATA_W = ((PAGE_W + SLOT_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] END_MARK    = {WORD_W{1'b1}};
  localparam logic [SLOT_W-1:0] RESET_LIMIT = {SLOT_W{1'b1}};

  // request kinds, code 3 is unused and answers a failure
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_GROW,
    S_WALK,
    S_RD_DATA,
    S_DEL_LINK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] page_id;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [PAGE_W-1:0] page_out;
  } res_t;

endpackage

// ----- src/sdfl_engine.sv -----
// slot store memory and the sequencer that walks and updates the free chain
module sdfl_engine import sdfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  input  logic [SLOT_W-1:0] slot_limit,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  // slot store, one write and one read port, registered read
  logic [WORD_W-1:0] mem [SLOTS];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata_r;
  logic              rd_unset_r;
  logic              e0_set_r;
  logic [WORD_W-1:0] rd_word;
  logic [SLOT_W-1:0] rd_link;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] hw_r, hw_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [REQ_W-1:0]  kind_r, kind_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  res_t              res_r, res_nxt;
  logic              grow;
  logic              ins_ok;

  // memory array, read-first on a same-address write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // entry 0 reads as the end mark until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_set_r   <= 1'b0;
      rd_unset_r <= 1'b0;
    end else begin
      if (mem_we && mem_waddr == '0) begin
        e0_set_r <= 1'b1;
      end
      if (mem_re) begin
        rd_unset_r <= (mem_raddr == '0) && !e0_set_r;
      end
    end
  end

  assign rd_word = rd_unset_r ? END_MARK : mem_rdata_r;
  assign rd_link = rd_word[SLOT_W-1:0];

  // control and chain pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      hw_r    <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      hw_r    <= hw_nxt;
      used_r  <= used_nxt;
    end
  end

  // walk and request payload
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    steps_r    <= steps_nxt;
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
  end

  assign grow   = (head_r == hw_r);
  assign ins_ok = (used_r < {1'b0, slot_limit}) && !(grow && hw_r == {SLOT_W{1'b1}});

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    hw_nxt       = hw_r;
    used_nxt     = used_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    has_prev_nxt = has_prev_r;
    steps_nxt    = steps_r;
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          kind_nxt  = req.req_type;
          idx_nxt   = req.slot_index;
          res_nxt   = '0;
          state_nxt = S_RESULT;
          case (req.req_type)
            REQ_INSERT: begin
              if (ins_ok) begin
                // store the id and, when not growing, fetch the old link in the same cycle
                mem_we           = 1'b1;
                mem_waddr        = head_r;
                mem_wdata        = {1'b0, req.page_id};
                res_nxt.ok       = 1'b1;
                res_nxt.slot_out = head_r;
                used_nxt         = used_r + CNT_W'(1);
                if (grow) begin
                  state_nxt = S_INS_GROW;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = head_r;
                  state_nxt = S_INS_RD;
                end
              end
            end
            REQ_DELETE, REQ_READ: begin
              if (req.slot_index < hw_r) begin
                cur_nxt      = head_r;
                prev_nxt     = '0;
                has_prev_nxt = 1'b0;
                steps_nxt    = '0;
                mem_re       = 1'b1;
                mem_raddr    = head_r;
                state_nxt    = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        head_nxt  = rd_link;
        state_nxt = S_RESULT;
      end
      S_INS_GROW: begin
        // new end slot just above the old one
        mem_we    = 1'b1;
        mem_waddr = hw_r + SLOT_W'(1);
        mem_wdata = END_MARK;
        hw_nxt    = hw_r + SLOT_W'(1);
        head_nxt  = hw_r + SLOT_W'(1);
        state_nxt = S_RESULT;
      end
      S_WALK: begin
        if (steps_r < CNT_W'(SLOTS) && rd_word != END_MARK && idx_r > cur_r) begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_link;
          steps_nxt    = steps_r + CNT_W'(1);
          mem_re       = 1'b1;
          mem_raddr    = rd_link;
        end else if (idx_r == cur_r) begin
          // slot is already free
          state_nxt = S_RESULT;
        end else if (kind_r == REQ_READ) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r;
          state_nxt = S_RD_DATA;
        end else begin
          // link the predecessor (or the head) to the freed slot
          if (has_prev_r) begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = WORD_W'(idx_r);
          end else begin
            head_nxt = idx_r;
          end
          state_nxt = S_DEL_LINK;
        end
      end
      S_RD_DATA: begin
        res_nxt.ok       = 1'b1;
        res_nxt.page_out = rd_word[PAGE_W-1:0];
        state_nxt        = S_RESULT;
      end
      S_DEL_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        mem_wdata  = WORD_W'(cur_r);
        used_nxt   = used_r - CNT_W'(1);
        res_nxt.ok = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ----- src/slot_directory_free_list_core.sv -----
// top level: stream ports, limit register and result register around the engine
// Throughput: one request in flight; the chain walk does one slot store read per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous, active low; all control clears without a clearing pass.
module slot_directory_free_list_core import sdfl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // page_id, slot_index, zero pad
  input  logic [REQ_W-1:0]   in_tuser,   // req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // slot_out, page_out, zero pad
  output logic               out_tuser,  // ok
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SLOT_W-1:0]  cfg_data    // slot_limit
);

  logic [SLOT_W-1:0] limit_r;
  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;
  res_t              out_res_r;

  // limit register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RESET_LIMIT;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // unpack the request
  assign req.req_type   = in_tuser;
  assign req.page_id    = in_tdata[PAGE_W-1:0];
  assign req.slot_index = in_tdata[PAGE_W+SLOT_W-1:PAGE_W];

  sdfl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .slot_limit (limit_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = TDATA_W'({out_res_r.page_out, out_res_r.slot_out});

endmodule

// ----- src/sdfl_checker.sv -----
// port-level checks of the slot directory free list, bound to the top level
module sdfl_checker import sdfl_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy right after taking one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in progress");

  // a failed request carries all-zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed result with nonzero data");

  // slot and page fields are never both set
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SLOT_W-1:0] == '0) || (out_tdata[TDATA_W-1:SLOT_W] == '0))
    else $error("slot and page both set in one result");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind slot_directory_free_list_core sdfl_checker u_sdfl_checker (.*);

// ----- verif/slot_directory_free_list_core_test.sv -----
// testbench of the slot directory free list core, checked against a predictor
`timescale 1ns / 100ps

module slot_directory_free_list_core_test import sdfl_pkg::*; ();

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 300;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic [REQ_W-1:0]   in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLOT_W-1:0]  cfg_data;

  // predicted directory state
  logic [WORD_W-1:0] dir_store [SLOTS];
  bit                slot_taken [SLOTS];
  logic [SLOT_W-1:0] free_head;
  logic [SLOT_W-1:0] high_water;
  logic [CNT_W-1:0]  used_count;
  logic [SLOT_W-1:0] slot_limit;

  res_t expected_results [$];
  res_t oldest_result;
  int   error_count;
  int   quiet_cycles;
  bit   no_idle;
  int   stall_left;

  slot_directory_free_list_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // walk the sorted free chain looking for idx
  function automatic bit walk_free_chain(input logic [SLOT_W-1:0] idx,
                                         output logic [SLOT_W-1:0] stop,
                                         output logic [SLOT_W-1:0] prev,
                                         output bit has_prev);
    logic [SLOT_W-1:0] cur;
    int steps;
    cur = free_head;
    steps = 0;
    prev = '0;
    has_prev = 1'b0;
    while (steps < SLOTS && dir_store[cur] != END_MARK && idx > cur) begin
      prev = cur;
      has_prev = 1'b1;
      cur = dir_store[cur][SLOT_W-1:0];
      steps++;
    end
    stop = cur;
    return idx == cur;
  endfunction

  // update the predicted directory for one accepted request, queue its result
  function automatic void predict_directory(input logic [REQ_W-1:0] kind,
                                            input logic [PAGE_W-1:0] page,
                                            input logic [SLOT_W-1:0] idx);
    res_t r;
    logic [SLOT_W-1:0] cur, stop, prev;
    bit has_prev;
    r = '0;
    case (kind)
      REQ_INSERT: begin
        cur = free_head;
        if (used_count < {1'b0, slot_limit} &&
            !(cur == high_water && high_water == SLOTS - 1)) begin
          if (cur == high_water) begin
            high_water = high_water + 1'b1;
            free_head = high_water;
            dir_store[high_water] = END_MARK;
          end else begin
            free_head = dir_store[cur][SLOT_W-1:0];
          end
          dir_store[cur] = {1'b0, page};
          slot_taken[cur] = 1'b1;
          used_count = used_count + 1'b1;
          r.ok = 1'b1;
          r.slot_out = cur;
        end
      end
      REQ_DELETE: begin
        if (idx < high_water && !walk_free_chain(idx, stop, prev, has_prev)) begin
          if (has_prev) dir_store[prev] = WORD_W'(idx);
          else free_head = idx;
          dir_store[idx] = WORD_W'(stop);
          slot_taken[idx] = 1'b0;
          used_count = used_count - 1'b1;
          r.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx < high_water && !walk_free_chain(idx, stop, prev, has_prev)) begin
          r.ok = 1'b1;
          r.page_out = dir_store[idx][PAGE_W-1:0];
        end
      end
      default: begin
      end
    endcase
    expected_results.push_back(r);
  endfunction

  // mostly short gaps, a few long ones, none in no-idle stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PAGE_W-1:0] random_page();
    return PAGE_W'($urandom);
  endfunction

  // slot to delete or read: mostly occupied slots, some at or below the high-water mark, some anywhere
  function automatic logic [SLOT_W-1:0] pick_slot();
    int r, start;
    r = $urandom_range(0, 9);
    start = $urandom_range(0, SLOTS - 1);
    if (r < 5) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_taken[(start + i) % SLOTS]) return SLOT_W'((start + i) % SLOTS);
    end
    if (r < 8) return SLOT_W'($urandom_range(0, high_water));
    return SLOT_W'(start);
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input int insert_pct, input int delete_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return REQ_INSERT;
    if (r < insert_pct + delete_pct) return REQ_DELETE;
    if (r < 97) return REQ_READ;
    return REQ_UNUSED;
  endfunction

  // send one request and predict its result once it is taken
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [PAGE_W-1:0] page,
                              input logic [SLOT_W-1:0] idx);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = kind;
    in_tdata = '0;
    in_tdata[PAGE_W-1:0] = page;
    in_tdata[PAGE_W +: SLOT_W] = idx;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_directory(kind, page, idx);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_requests();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_limit(input logic [SLOT_W-1:0] value);
    drain_requests();
    @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    slot_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // empty directory: out of range, unknown request
  task automatic test_empty_directory();
    send_request(REQ_UNUSED, '0, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_READ, '1, '1);
    send_request(REQ_DELETE, '1, '1);
  endtask

  // insert, read, delete with holes, reuse of freed slots in ascending order
  task automatic test_basic_requests();
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_INSERT, random_page(), '1);
    send_request(REQ_READ, '0, 8'd0);
    send_request(REQ_READ, '1, 8'd1);
    send_request(REQ_READ, '0, 8'd3);
    send_request(REQ_READ, '0, 8'd4);
    send_request(REQ_DELETE, '0, 8'd2);
    send_request(REQ_DELETE, '0, 8'd0);
    send_request(REQ_READ, '0, 8'd2);
    send_request(REQ_DELETE, '0, 8'd2);
    send_request(REQ_DELETE, '0, 8'd4);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_READ, '0, 8'd4);
    send_request(REQ_UNUSED, '1, '1);
  endtask

  // limit at zero and lowered below the occupied count only blocks inserts
  task automatic test_slot_limit();
    write_slot_limit(8'd0);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_READ, '0, 8'd1);
    write_slot_limit(8'd2);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_DELETE, '0, 8'd1);
    send_request(REQ_INSERT, random_page(), '0);
    send_request(REQ_READ, '0, 8'd3);
    write_slot_limit(8'd255);
  endtask

  // fill to the limit at the top of the store, then thin out with long chain walks
  task automatic test_fill_and_drain();
    no_idle = 1'b1;
    repeat (260) send_request(REQ_INSERT, random_page(), pick_slot());
    no_idle = 1'b0;
    send_request(REQ_READ, '0, 8'd254);
    send_request(REQ_READ, '0, 8'd255);
    repeat (160) begin
      if ($urandom_range(0, 2) == 0) send_request(REQ_READ, random_page(), pick_slot());
      else send_request(REQ_DELETE, random_page(), pick_slot());
    end
    repeat (4) send_request(REQ_DELETE, '0, 8'd254);
  endtask

  // random traffic in phases that grow and shrink the directory under several limits
  task automatic test_random_traffic();
    logic [SLOT_W-1:0] limits [6];
    limits[0] = 8'd255;
    limits[1] = SLOT_W'($urandom_range(16, 64));
    limits[2] = 8'd254;
    limits[3] = 8'd1;
    limits[4] = SLOT_W'($urandom_range(0, 255));
    limits[5] = 8'd255;
    for (int phase = 0; phase < 6; phase++) begin
      write_slot_limit(limits[phase]);
      no_idle = (phase == 2);
      repeat (200) begin
        if (phase % 2 == 0)
          send_request(pick_kind(60, 20), random_page(), pick_slot());
        else
          send_request(pick_kind(25, 45), random_page(), pick_slot());
      end
    end
    no_idle = 1'b0;
  endtask

  // result side stalls
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: ok %0d", out_tuser);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_tuser !== oldest_result.ok) begin
          $error("ok: expected %0d, actual %0d", oldest_result.ok, out_tuser);
          error_count++;
        end
        if (out_tdata[SLOT_W-1:0] !== oldest_result.slot_out) begin
          $error("slot_out: expected %0d, actual %0d", oldest_result.slot_out,
                 out_tdata[SLOT_W-1:0]);
          error_count++;
        end
        if (out_tdata[SLOT_W +: PAGE_W] !== oldest_result.page_out) begin
          $error("page_out: expected %0h, actual %0h", oldest_result.page_out,
                 out_tdata[SLOT_W +: PAGE_W]);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("slot_directory_free_list_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_INSERT;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      dir_store[i] = '0;
      slot_taken[i] = 1'b0;
    end
    dir_store[0] = END_MARK;
    free_head = '0;
    high_water = '0;
    used_count = '0;
    slot_limit = RESET_LIMIT;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_directory();
    test_basic_requests();
    test_slot_limit();
    test_fill_and_drain();
    test_random_traffic();

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("slot_directory_free_list_core_test: PASS");
    else
      $display("slot_directory_free_list_core_test: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sdfl_pkg.sv
src/sdfl_engine.sv
src/slot_directory_free_list_core.sv
src/sdfl_checker.sv
verif/slot_directory_free_list_core_test.sv
